[rtl/assert_macros.svh]
// Assertion macros shared by the checkbox counter RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define MCC_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("%m: assertion failed");

// Antecedent in a given cycle implies consequent in the next cycle.
`define MCC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

[rtl/mcc_pkg.sv]
// Package for the checkbox counter: count width, character codes and shared types.
// Depends on nothing; imported by every module of the block.
package mcc_pkg;

  localparam int unsigned COUNT_WIDTH = 16;
  localparam int unsigned OUT_COUNT_W = 16;
  localparam int unsigned EXT_W = (COUNT_WIDTH > OUT_COUNT_W) ? COUNT_WIDTH : OUT_COUNT_W;

  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LOW_X  = 8'h78;
  localparam logic [7:0] CH_UP_X   = 8'h58;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;

  typedef logic [COUNT_WIDTH-1:0] count_t;

  typedef struct packed {
    logic tally;
    logic done;
  } tally_t;

endpackage

[rtl/mcc_line_scan.sv]
// Line scanner: phase and mark registers that recognise task-list lines.
// Depends on mcc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mcc_line_scan
  import mcc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       adv_i,
  input  logic [7:0] byte_i,
  input  logic       last_i,
  output tally_t     tally_o
);

  typedef enum logic [2:0] {
    PH_LEAD, PH_BULLET, PH_GAP, PH_OPEN, PH_MARK, PH_CLOSE, PH_PENDCR, PH_SKIP
  } phase_e;

  typedef enum logic [1:0] {
    MARK_NONE, MARK_OPEN, MARK_DONE
  } mark_e;

  phase_e phase_q, phase_d, phase_n;
  mark_e  mark_q, mark_d, mark_n;
  logic   blank;
  logic   tally_line;

  assign blank = (byte_i == CH_SPACE) || (byte_i == CH_TAB);

  always_comb begin
    phase_n    = phase_q;
    mark_n     = mark_q;
    tally_line = 1'b0;
    if (byte_i == CH_LF) begin
      tally_line = (phase_q == PH_CLOSE) || (phase_q == PH_PENDCR);
      phase_n    = PH_LEAD;
      mark_n     = MARK_NONE;
    end else begin
      case (phase_q)
        PH_LEAD: begin
          if ((byte_i == CH_DASH) || (byte_i == CH_STAR) || (byte_i == CH_PLUS)) begin
            phase_n = PH_BULLET;
          end else if (!blank) begin
            phase_n = PH_SKIP;
          end
        end
        PH_BULLET: begin
          phase_n = blank ? PH_GAP : PH_SKIP;
        end
        PH_GAP: begin
          if (byte_i == CH_LBRACK) begin
            phase_n = PH_OPEN;
          end else if (!blank) begin
            phase_n = PH_SKIP;
          end
        end
        PH_OPEN: begin
          if (byte_i == CH_SPACE) begin
            mark_n  = MARK_OPEN;
            phase_n = PH_MARK;
          end else if ((byte_i == CH_LOW_X) || (byte_i == CH_UP_X)) begin
            mark_n  = MARK_DONE;
            phase_n = PH_MARK;
          end else begin
            phase_n = PH_SKIP;
          end
        end
        PH_MARK: begin
          phase_n = (byte_i == CH_RBRACK) ? PH_CLOSE : PH_SKIP;
        end
        PH_CLOSE: begin
          if (blank) begin
            tally_line = 1'b1;
            phase_n    = PH_SKIP;
          end else if (byte_i == CH_CR) begin
            phase_n = PH_PENDCR;
          end else begin
            phase_n = PH_SKIP;
          end
        end
        default: begin
          phase_n = PH_SKIP;
        end
      endcase
    end

    tally_o.tally = tally_line ||
                    (last_i && ((phase_n == PH_CLOSE) || (phase_n == PH_PENDCR)));
    tally_o.done  = (mark_q == MARK_DONE);

    if (last_i) begin
      phase_d = PH_LEAD;
      mark_d  = MARK_NONE;
    end else begin
      phase_d = phase_n;
      mark_d  = mark_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_LEAD;
      mark_q  <= MARK_NONE;
    end else if (adv_i) begin
      phase_q <= phase_d;
      mark_q  <= mark_d;
    end
  end

  `MCC_ASSERT_NEXT(a_scan_clear_at_end, clk_i, rst_ni, adv_i && last_i,
                   (phase_q == PH_LEAD) && (mark_q == MARK_NONE))

endmodule

[rtl/mcc_tally_count.sv]
// Saturating counters for all checkbox lines and for done checkbox lines.
// Depends on mcc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mcc_tally_count
  import mcc_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   adv_i,
  input  logic   last_i,
  input  tally_t tally_i,
  output count_t total_o,
  output count_t done_o
);

  localparam count_t COUNT_MAX = '1;

  count_t total_q, total_n;
  count_t done_q, done_n;

  always_comb begin
    total_n = total_q;
    done_n  = done_q;
    if (tally_i.tally && (total_q != COUNT_MAX)) begin
      total_n = total_q + count_t'(1);
    end
    if (tally_i.tally && tally_i.done && (done_q != COUNT_MAX)) begin
      done_n = done_q + count_t'(1);
    end
  end

  assign total_o = total_n;
  assign done_o  = done_n;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
      done_q  <= '0;
    end else if (adv_i) begin
      total_q <= last_i ? '0 : total_n;
      done_q  <= last_i ? '0 : done_n;
    end
  end

  `MCC_ASSERT(a_done_within_total, clk_i, rst_ni, done_q <= total_q)
  `MCC_ASSERT_NEXT(a_counts_clear_at_end, clk_i, rst_ni, adv_i && last_i,
                   (total_q == '0) && (done_q == '0))

endmodule

[rtl/markdown_checkbox_counter_unit.sv]
// Top level of the checkbox counter: input register, scanner, counters, output register.
// Depends on mcc_pkg, mcc_line_scan, mcc_tally_count and assert_macros.svh.
//
// The block takes a text body on the slave stream, one byte per word, with
// s_axis_tlast set on the final byte of the body. For every byte it returns
// one word on the master stream holding the running count of task-list lines
// and of checked task-list lines, both saturating. m_axis_tlast is set on the
// word for the final byte, whose counts are then final for the whole body;
// the counts and the line state clear afterwards for the next body.
// A byte passes through an input register and then through the scanner and
// counter logic into the output register. One byte is accepted per cycle while
// the receiver takes every result word, set by the single phase register
// update per byte. When the receiver stalls, the result word holds and the
// input register still takes one more byte; then s_axis_tready drops until
// the output is taken. Reset clears both registers' valid flags, the line
// phase and the counts; no word is lost across a stall.
`include "assert_macros.svh"

module markdown_checkbox_counter_unit
  import mcc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
  input  logic        s_axis_tlast,   // end_of_body
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [15:0] total_count, [31:16] done_count
  output logic        m_axis_tlast    // body_finished
);

  logic       in_v_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  logic       out_v_q;
  logic [OUT_COUNT_W-1:0] out_total_q, out_done_q;
  logic       out_last_q;
  logic       out_free;
  logic       adv;
  tally_t     tally;
  count_t     total_n, done_n;
  logic [EXT_W-1:0] total_ext, done_ext;

  assign out_free      = !out_v_q || m_axis_tready;
  assign adv           = in_v_q && out_free;
  assign s_axis_tready = !in_v_q || out_free;

  mcc_line_scan u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .byte_i  (in_byte_q),
    .last_i  (in_last_q),
    .tally_o (tally)
  );

  mcc_tally_count u_count (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .last_i  (in_last_q),
    .tally_i (tally),
    .total_o (total_n),
    .done_o  (done_n)
  );

  assign total_ext = EXT_W'(total_n);
  assign done_ext  = EXT_W'(done_n);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_v_q <= 1'b1;
    end else if (adv) begin
      in_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_total_q <= total_ext[OUT_COUNT_W-1:0];
      out_done_q  <= done_ext[OUT_COUNT_W-1:0];
      out_last_q  <= in_last_q;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {out_done_q, out_total_q};
  assign m_axis_tlast  = out_last_q;

  `MCC_ASSERT(a_stall_only_when_full, clk_i, rst_ni,
              s_axis_tready || (in_v_q && out_v_q && !m_axis_tready))
  `MCC_ASSERT_NEXT(a_advance_fills_output, clk_i, rst_ni, adv, out_v_q)

endmodule
